// ----- rtl/fldb_pkg.sv -----
package fldb_pkg;

    // Build-time defaults
    localparam int MAX_POSITIONS_DEF = 1024;

    // Field and register widths
    localparam int POS_W     = 10;
    localparam int LEVEL_W   = 16;
    localparam int RES_CFG_W = 11;
    localparam int FRAC_W    = 17;
    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 32;
    localparam int REG_IDX_W = 2;

    // Arithmetic
    localparam int FRAC_ONE      = 65536;
    localparam int FRAC_SHIFT    = 16;
    localparam int HUNDRED_DB_Q8 = 25600;
    localparam int COEF_W        = 18;  // 25600 + top + 2*half
    localparam int QUO_W         = 17;  // quotient magnitude bits
    localparam int ACC_W         = 20;
    localparam int LEVEL_MAX     = 32767;
    localparam int LEVEL_MIN     = -32768;

    // Register map
    localparam logic [REG_IDX_W-1:0] REG_POSITIONS = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_HALF      = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_TOP       = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_CUTOFF    = 2'd3;

    localparam logic [RES_CFG_W-1:0]      RST_POSITIONS = 11'd1024;
    localparam logic signed [LEVEL_W-1:0] RST_HALF      = -16'sd2560;
    localparam logic signed [LEVEL_W-1:0] RST_TOP       = 16'sd2560;
    localparam logic [FRAC_W-1:0]         RST_CUTOFF    = 17'd13107;

    // Request opcodes
    localparam logic OP_POS_TO_DB = 1'b0;
    localparam logic OP_DB_TO_POS = 1'b1;

    // Step selection for one law evaluation
    localparam logic [1:0] P_SRC_POS  = 2'd0;
    localparam logic [1:0] P_SRC_ZERO = 2'd1;
    localparam logic [1:0] P_SRC_LAST = 2'd2;
    localparam logic [1:0] P_SRC_MID  = 2'd3;

    // Result selection
    localparam logic [2:0] RES_LEVEL = 3'd0;
    localparam logic [2:0] RES_ZERO  = 3'd1;
    localparam logic [2:0] RES_LAST  = 3'd2;
    localparam logic [2:0] RES_MID   = 3'd3;
    localparam logic [2:0] RES_LO    = 3'd4;

    typedef struct packed {
        logic                      op;
        logic [POS_W-1:0]          fader_position;
        logic signed [LEVEL_W-1:0] level_in_db;
    } in_item_t;

    typedef struct packed {
        logic signed [LEVEL_W-1:0] level_out_db;
        logic [POS_W-1:0]          position_out;
    } out_item_t;

    typedef struct packed {
        logic [RES_CFG_W-1:0]      positions_in_use;
        logic signed [LEVEL_W-1:0] half_range_db;
        logic signed [LEVEL_W-1:0] top_level_db;
        logic [FRAC_W-1:0]         cutoff_fraction;
    } cfg_t;

    typedef struct packed {
        logic       take;
        logic       setup;
        logic       csq;
        logic       p_load;
        logic [1:0] p_src;
        logic       mul;
        logic       mul2;
        logic       div_go;
        logic       div_att;
        logic       lin_acc;
        logic       att_acc;
        logic       sat;
        logic       srch_init;
        logic       srch_upd;
        logic       res_load;
        logic [2:0] res_src;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic op;
        logic below;
        logic div_done;
        logic key_le;
        logic key_ge;
        logic lo_gt_hi;
    } sts_t;

endpackage

// ----- rtl/fldb_div.sv -----
// Signed / unsigned restoring divider, one quotient bit per cycle.
// Quotient magnitude must fit QUO_W bits; truncates toward zero.
module fldb_div import fldb_pkg::*; #(
    parameter int STEP_W = $clog2(MAX_POSITIONS_DEF)
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic signed [QUO_W+2*STEP_W:0] num,
    input  logic [2*STEP_W-1:0]        den,
    output logic                       done,
    output logic signed [QUO_W:0]      quo
);

    localparam int DEN_W = 2 * STEP_W;
    localparam int NUM_W = QUO_W + 1 + DEN_W;
    localparam int MAG_W = NUM_W - 1;
    localparam int CNT_W = $clog2(QUO_W + 1);

    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [QUO_W-1:0] qr_reg;
    logic [DEN_W-1:0] den_reg;
    logic             neg_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [NUM_W-1:0] num_abs;
    logic [DEN_W:0]   trial;
    logic             fits;
    logic [QUO_W:0]   q_ext;

    assign num_abs  = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    assign trial    = {rem_reg, qr_reg[QUO_W-1]};
    assign fits     = trial >= {1'b0, den_reg};
    assign rem_next = fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
    assign q_ext    = {1'b0, qr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(QUO_W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end else begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= num_abs[MAG_W-1:QUO_W];
            qr_reg  <= num_abs[QUO_W-1:0];
            den_reg <= den;
            neg_reg <= num[NUM_W-1];
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            qr_reg  <= {qr_reg[QUO_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quo  = neg_reg ? $signed(-q_ext) : $signed(q_ext);

endmodule

// ----- rtl/fldb_dp.sv -----
// Law datapath: setup of n and cutoff, two multiplies, shared divider,
// accumulate and saturate, binary search bounds, result registers.
module fldb_dp import fldb_pkg::*; #(
    parameter int MAX_POSITIONS = MAX_POSITIONS_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  cmd_t      cmd,
    output sts_t      sts,
    input  in_item_t  s_data,
    input  cfg_t      cfg,
    output out_item_t m_data
);

    localparam int SW    = $clog2(MAX_POSITIONS);
    localparam int DEN_W = 2 * SW;
    localparam int NUM_W = QUO_W + 1 + DEN_W;
    localparam int CMP_W = (SW + 1 > RES_CFG_W) ? SW + 1 : RES_CFG_W;
    localparam int PCW   = (SW > POS_W) ? SW : POS_W;

    in_item_t                  item_reg;
    logic [SW-1:0]             n_reg;
    logic [SW-1:0]             c_reg;
    logic [DEN_W-1:0]          csq_reg;
    logic signed [COEF_W-1:0]  coef_reg;
    logic [SW-1:0]             p_reg;
    logic signed [NUM_W-1:0]   lin_num_reg;
    logic signed [NUM_W-1:0]   att_num_reg;
    logic [DEN_W-1:0]          dsq_reg;
    logic                      below_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [LEVEL_W-1:0] law_reg;
    logic [SW:0]               lo_reg;
    logic [SW:0]               hi_reg;
    out_item_t                 res_reg;
    out_item_t                 out_reg;

    logic [CMP_W-1:0]          res_ext, res_clamp;
    logic [SW-1:0]             n_next;
    logic signed [COEF_W-1:0]  coef_next;
    logic [FRAC_W-1:0]         frac_sat;
    logic [FRAC_W+SW-1:0]      c_prod;
    logic [SW-1:0]             pos_clamp;
    logic [SW+1:0]             lo_hi_sum;
    logic [SW-1:0]             mid;
    logic [SW-1:0]             p_sel;
    logic [SW-1:0]             diff;
    logic [SW-1:0]             d_val;
    logic signed [LEVEL_W:0]   half2;
    logic signed [LEVEL_W+SW+1:0] lin_prod;
    logic signed [COEF_W+DEN_W:0] att_prod;
    logic signed [NUM_W-1:0]   div_num;
    logic [DEN_W-1:0]          div_den;
    logic                      div_done;
    logic signed [QUO_W:0]     quo;
    logic [SW-1:0]             lo_lim;
    logic [SW-1:0]             res_pos;

    // Resolution clamp, n = res - 1
    assign res_ext   = CMP_W'(cfg.positions_in_use);
    assign res_clamp = (res_ext < CMP_W'(2)) ? CMP_W'(2) :
                       (res_ext > CMP_W'(MAX_POSITIONS)) ? CMP_W'(MAX_POSITIONS) : res_ext;
    assign n_next    = SW'(res_clamp - CMP_W'(1));

    assign coef_next = COEF_W'(HUNDRED_DB_Q8) + COEF_W'($signed(cfg.top_level_db))
                     + (COEF_W'($signed(cfg.half_range_db)) <<< 1);

    assign frac_sat = (cfg.cutoff_fraction > FRAC_W'(FRAC_ONE)) ? FRAC_W'(FRAC_ONE)
                                                                : cfg.cutoff_fraction;
    assign c_prod   = (FRAC_W+SW)'(frac_sat) * (FRAC_W+SW)'(n_reg);

    assign pos_clamp = (PCW'(item_reg.fader_position) > PCW'(n_reg)) ? n_reg
                     : SW'(item_reg.fader_position);

    assign lo_hi_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid       = lo_hi_sum[SW:1];

    always_comb begin
        case (cmd.p_src)
            P_SRC_POS:  p_sel = pos_clamp;
            P_SRC_ZERO: p_sel = '0;
            P_SRC_LAST: p_sel = n_reg;
            default:    p_sel = mid;
        endcase
    end

    assign diff     = n_reg - p_reg;
    assign d_val    = (p_reg < c_reg) ? (c_reg - p_reg) : '0;
    assign half2    = $signed({cfg.half_range_db, 1'b0});
    assign lin_prod = half2 * $signed({1'b0, diff});
    assign att_prod = coef_reg * $signed({1'b0, dsq_reg});

    assign div_num = cmd.div_att ? att_num_reg : lin_num_reg;
    assign div_den = cmd.div_att ? csq_reg : DEN_W'(n_reg);

    fldb_div #(
        .STEP_W(SW)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_go),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (quo)
    );

    assign lo_lim = (lo_reg > {1'b0, n_reg}) ? n_reg : lo_reg[SW-1:0];

    always_comb begin
        case (cmd.res_src)
            RES_LAST: res_pos = n_reg;
            RES_MID:  res_pos = mid;
            RES_LO:   res_pos = lo_lim;
            default:  res_pos = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            item_reg <= s_data;
            n_reg    <= n_next;
            coef_reg <= coef_next;
        end
        if (cmd.setup) begin
            c_reg <= SW'(c_prod >> FRAC_SHIFT);
        end
        if (cmd.csq) begin
            csq_reg <= DEN_W'(c_reg) * DEN_W'(c_reg);
        end
        if (cmd.p_load) begin
            p_reg <= p_sel;
        end
        if (cmd.mul) begin
            lin_num_reg <= NUM_W'(lin_prod);
            dsq_reg     <= DEN_W'(d_val) * DEN_W'(d_val);
            below_reg   <= p_reg < c_reg;
        end
        if (cmd.mul2) begin
            att_num_reg <= NUM_W'(att_prod);
        end
        if (cmd.lin_acc) begin
            acc_reg <= ACC_W'($signed(cfg.top_level_db)) + ACC_W'(quo);
        end else if (cmd.att_acc) begin
            acc_reg <= acc_reg - ACC_W'(quo);
        end
        if (cmd.sat) begin
            if (acc_reg > $signed(ACC_W'(LEVEL_MAX))) begin
                law_reg <= LEVEL_W'(LEVEL_MAX);
            end else if (acc_reg < $signed(ACC_W'(LEVEL_MIN))) begin
                law_reg <= LEVEL_W'(LEVEL_MIN);
            end else begin
                law_reg <= LEVEL_W'(acc_reg);
            end
        end
        if (cmd.srch_init) begin
            lo_reg <= '0;
            hi_reg <= {1'b0, n_reg};
        end else if (cmd.srch_upd) begin
            if (!sts.key_le) begin
                lo_reg <= {1'b0, mid} + 1'b1;
            end else begin
                hi_reg <= {1'b0, mid} - 1'b1;
            end
        end
        if (cmd.res_load) begin
            if (cmd.res_src == RES_LEVEL) begin
                res_reg.level_out_db <= law_reg;
                res_reg.position_out <= '0;
            end else begin
                res_reg.level_out_db <= '0;
                res_reg.position_out <= POS_W'(res_pos);
            end
        end
        if (cmd.out_load) begin
            out_reg <= res_reg;
        end
    end

    assign sts.op       = item_reg.op;
    assign sts.below    = below_reg;
    assign sts.div_done = div_done;
    assign sts.key_le   = $signed(item_reg.level_in_db) <= law_reg;
    assign sts.key_ge   = $signed(item_reg.level_in_db) >= law_reg;
    assign sts.lo_gt_hi = lo_reg > hi_reg;

    assign m_data = out_reg;

endmodule

// ----- rtl/fldb_ctrl.sv -----
// Sequencer: item intake, law evaluation steps, end checks and
// binary search, output register handshake.
module fldb_ctrl import fldb_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    output logic m_valid,
    input  logic m_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SETUP = 4'd1;
    localparam logic [3:0] ST_CSQ   = 4'd2;
    localparam logic [3:0] ST_PSEL  = 4'd3;
    localparam logic [3:0] ST_MUL   = 4'd4;
    localparam logic [3:0] ST_MUL2  = 4'd5;
    localparam logic [3:0] ST_DLIN  = 4'd6;
    localparam logic [3:0] ST_DATT  = 4'd7;
    localparam logic [3:0] ST_SAT   = 4'd8;
    localparam logic [3:0] ST_CHECK = 4'd9;
    localparam logic [3:0] ST_LOOP  = 4'd10;
    localparam logic [3:0] ST_OUT   = 4'd11;

    // What the current law evaluation is for
    localparam logic [1:0] PH_OP0 = 2'd0;
    localparam logic [1:0] PH_BOT = 2'd1;
    localparam logic [1:0] PH_TOP = 2'd2;
    localparam logic [1:0] PH_MID = 2'd3;

    logic [3:0] state_reg, state_next;
    logic [1:0] phase_reg, phase_next;
    logic       m_valid_reg;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        phase_next = phase_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.take   = 1'b1;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                cmd.setup  = 1'b1;
                state_next = ST_CSQ;
            end
            ST_CSQ: begin
                cmd.csq    = 1'b1;
                phase_next = (sts.op == OP_DB_TO_POS) ? PH_BOT : PH_OP0;
                state_next = ST_PSEL;
            end
            ST_PSEL: begin
                cmd.p_load = 1'b1;
                unique case (phase_reg)
                    PH_OP0:  cmd.p_src = P_SRC_POS;
                    PH_BOT:  cmd.p_src = P_SRC_ZERO;
                    PH_TOP:  cmd.p_src = P_SRC_LAST;
                    default: cmd.p_src = P_SRC_MID;
                endcase
                state_next = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2: begin
                cmd.mul2   = 1'b1;
                cmd.div_go = 1'b1;
                state_next = ST_DLIN;
            end
            ST_DLIN: begin
                if (sts.div_done) begin
                    cmd.lin_acc = 1'b1;
                    if (sts.below) begin
                        cmd.div_go  = 1'b1;
                        cmd.div_att = 1'b1;
                        state_next  = ST_DATT;
                    end else begin
                        state_next = ST_SAT;
                    end
                end
            end
            ST_DATT: begin
                if (sts.div_done) begin
                    cmd.att_acc = 1'b1;
                    state_next  = ST_SAT;
                end
            end
            ST_SAT: begin
                cmd.sat    = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                unique case (phase_reg)
                    PH_OP0: begin
                        cmd.res_load = 1'b1;
                        cmd.res_src  = RES_LEVEL;
                        state_next   = ST_OUT;
                    end
                    PH_BOT: begin
                        if (sts.key_le) begin
                            cmd.res_load = 1'b1;
                            cmd.res_src  = RES_ZERO;
                            state_next   = ST_OUT;
                        end else begin
                            phase_next = PH_TOP;
                            state_next = ST_PSEL;
                        end
                    end
                    PH_TOP: begin
                        if (sts.key_ge) begin
                            cmd.res_load = 1'b1;
                            cmd.res_src  = RES_LAST;
                            state_next   = ST_OUT;
                        end else begin
                            cmd.srch_init = 1'b1;
                            phase_next    = PH_MID;
                            state_next    = ST_LOOP;
                        end
                    end
                    default: begin
                        if (sts.key_le && sts.key_ge) begin
                            cmd.res_load = 1'b1;
                            cmd.res_src  = RES_MID;
                            state_next   = ST_OUT;
                        end else begin
                            cmd.srch_upd = 1'b1;
                            state_next   = ST_LOOP;
                        end
                    end
                endcase
            end
            ST_LOOP: begin
                if (sts.lo_gt_hi) begin
                    cmd.res_load = 1'b1;
                    cmd.res_src  = RES_LO;
                    state_next   = ST_OUT;
                end else begin
                    state_next = ST_PSEL;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= PH_OP0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second request taken while one is in flight");

    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_OUT))
        else $error("result valid raised outside output step");

    a_div_expected: assert property (@(posedge aclk) disable iff (!aresetn)
        sts.div_done |-> (state_reg == ST_DLIN || state_reg == ST_DATT))
        else $error("divider finished while sequencer not waiting");

endmodule

// ----- rtl/fader_law_db_mapper.sv -----
// Channel  | Ports                                   | Direction | Payload
// ---------+-----------------------------------------+-----------+-----------------------------
// request  | s_valid, s_ready, s_data                | in        | op, fader_position,
//          |                                         |           | level_in_db
// result   | m_valid, m_ready, m_data                | out       | level_out_db, position_out
// config   | psel, penable, pwrite, paddr, pwdata,   | in/out    | 4 registers at 0x0..0xC
//          | prdata, pready                          |           |
//
// Sequencing: one law evaluation runs the shared bit-serial divider for the
//   linear quotient and, below the cutoff step only, the attenuation quotient:
//   17 quotient bits each, one per cycle.
//   op 0 (position to dB): one evaluation per request.
//   op 1 (dB to position): two end evaluations plus up to k = floor(log2(res))+1
//   search probes.
// Reset: aresetn is synchronous, active low; registers return to 1024 steps,
//   half range -10 dB, top +10 dB, cutoff 0.2.
// Stalls: results sit in an output register; a request is taken once the
//   previous result has moved into it, even while that result still waits.
//   The sequencer only waits on a full output register in its final step.
module fader_law_db_mapper import fldb_pkg::*; #(
    parameter int MAX_POSITIONS = MAX_POSITIONS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    // APB-style configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    // Request channel
    input  logic              s_valid,
    output logic              s_ready,
    input  in_item_t          s_data,
    // Result channel
    output logic              m_valid,
    input  logic              m_ready,
    output out_item_t         m_data
);

    cfg_t                 cfg_reg;
    logic                 cfg_wr;
    logic [REG_IDX_W-1:0] reg_idx;
    cmd_t                 cmd;
    sts_t                 sts;

    // Register file: word addressed, low address bits ignored
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.positions_in_use <= RST_POSITIONS;
            cfg_reg.half_range_db    <= RST_HALF;
            cfg_reg.top_level_db     <= RST_TOP;
            cfg_reg.cutoff_fraction  <= RST_CUTOFF;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_POSITIONS: cfg_reg.positions_in_use <= pwdata[RES_CFG_W-1:0];
                REG_HALF:      cfg_reg.half_range_db    <= pwdata[LEVEL_W-1:0];
                REG_TOP:       cfg_reg.top_level_db     <= pwdata[LEVEL_W-1:0];
                default:       cfg_reg.cutoff_fraction  <= pwdata[FRAC_W-1:0];
            endcase
        end
    end

    // Readback: signed levels come back sign extended
    always_comb begin
        unique case (reg_idx)
            REG_POSITIONS: prdata = DATA_W'(cfg_reg.positions_in_use);
            REG_HALF:      prdata = DATA_W'($signed(cfg_reg.half_range_db));
            REG_TOP:       prdata = DATA_W'($signed(cfg_reg.top_level_db));
            default:       prdata = DATA_W'(cfg_reg.cutoff_fraction);
        endcase
    end

    // Sequencer
    fldb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Law arithmetic, search bounds and result registers
    fldb_dp #(
        .MAX_POSITIONS(MAX_POSITIONS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .sts     (sts),
        .s_data  (s_data),
        .cfg     (cfg_reg),
        .m_data  (m_data)
    );

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

// Fader law mapper bench.
// A directed plan runs first: ends of the law, both operations, clamped
// resolution, steps past the last one, cutoff above one, and extreme dB
// settings. Then random phases follow, each with a fresh set of registers
// and a batch of random requests. Every result is checked, against the value
// written in the plan or a model of the law that the bench computes itself.
module testbench;
    import fldb_pkg::*;

    // ------------------------------------------------------------------
    // Clock and DUT ports
    // ------------------------------------------------------------------
    logic              aclk = 1'b0;
    logic              aresetn;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              s_valid;
    logic              s_ready;
    in_item_t          s_data;
    logic              m_valid;
    logic              m_ready;
    out_item_t         m_data;

    always #4 aclk = ~aclk;

    fader_law_db_mapper u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // ------------------------------------------------------------------
    // Register shadow, updated at the edge where the DUT takes a write
    // ------------------------------------------------------------------
    logic [RES_CFG_W-1:0]      res_cfg;
    logic signed [LEVEL_W-1:0] half_cfg;
    logic signed [LEVEL_W-1:0] top_cfg;
    logic [FRAC_W-1:0]         cut_cfg;

    // Results still owed by the DUT, oldest first
    out_item_t pending_results[$];

    int  fault_count;
    int  sent_count;
    int  burst_left;

    // ------------------------------------------------------------------
    // Law model
    // ------------------------------------------------------------------

    // Last step index n = res-1, res clamped to [2, MAX_POSITIONS_DEF].
    function automatic int unsigned last_index();
        int unsigned r;
        r = res_cfg;
        if (r < 2) r = 2;
        if (r > MAX_POSITIONS_DEF) r = MAX_POSITIONS_DEF;
        return r - 1;
    endfunction

    // Level of step p, Q7.8: top level plus linear quotient, minus the quadratic attenuation
    // below the cutoff step, each truncated toward zero, then saturated.
    function automatic logic signed [LEVEL_W-1:0] fader_level(input int unsigned p,
                                                              input int unsigned n);
        longint half_l;
        longint top_l;
        longint val;
        longint frac;
        longint cstep;
        longint d;
        longint coef;
        half_l = half_cfg;
        top_l  = top_cfg;
        val    = top_l + (2 * half_l * longint'(n - p)) / longint'(n);
        frac   = (cut_cfg > FRAC_ONE) ? FRAC_ONE : longint'(cut_cfg);
        cstep  = (frac * longint'(n)) >>> FRAC_SHIFT;
        if (longint'(p) < cstep) begin
            d    = cstep - longint'(p);
            coef = HUNDRED_DB_Q8 + top_l + 2 * half_l;
            val  = val - (coef * d * d) / (cstep * cstep);
        end
        if (val > LEVEL_MAX) val = LEVEL_MAX;
        if (val < LEVEL_MIN) val = LEVEL_MIN;
        return val[LEVEL_W-1:0];
    endfunction

    // Inverse law: clamp at both ends, else binary search for the exact
    // step or the insertion point.
    function automatic int unsigned step_for_level(input logic signed [LEVEL_W-1:0] key,
                                                   input int unsigned n);
        int lo;
        int hi;
        int mid;
        logic signed [LEVEL_W-1:0] v;
        if (key <= fader_level(0, n)) return 0;
        if (key >= fader_level(n, n)) return n;
        lo = 0;
        hi = n;
        while (lo <= hi) begin
            mid = (lo + hi) >>> 1;
            v   = fader_level(mid, n);
            if (v < key) lo = mid + 1;
            else if (v > key) hi = mid - 1;
            else return mid;
        end
        return (lo > int'(n)) ? n : lo;
    endfunction

    function automatic out_item_t mapped_result(input in_item_t req);
        out_item_t   res;
        int unsigned n;
        int unsigned p;
        n   = last_index();
        res = '0;
        if (req.op == OP_POS_TO_DB) begin
            p = req.fader_position;
            if (p > n) p = n;      // step past the last one saturates
            res.level_out_db = fader_level(p, n);
        end else begin
            p = step_for_level(req.level_in_db, n);
            res.position_out = p[POS_W-1:0];
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Directed plan: requests and register writes in one table
    // ------------------------------------------------------------------
    typedef enum logic {ROW_REQ, ROW_WRITE} row_kind_e;

    typedef struct {
        row_kind_e            kind;
        logic [REG_IDX_W-1:0] reg_idx;
        logic [DATA_W-1:0]    wdata;
        in_item_t             req;
        bit                   typed;   // expectation written in the table
        out_item_t            want;
    } plan_row_t;

    plan_row_t plan[$];

    function automatic void plan_req(input logic op, input int pos, input int lvl);
        plan_row_t r;
        r = '{kind: ROW_REQ, default: '0};
        r.req.op             = op;
        r.req.fader_position = pos[POS_W-1:0];
        r.req.level_in_db    = lvl[LEVEL_W-1:0];
        plan.push_back(r);
    endfunction

    function automatic void plan_req_known(input logic op, input int pos, input int lvl,
                                           input int lvl_out, input int pos_out);
        plan_req(op, pos, lvl);
        plan[$].typed             = 1'b1;
        plan[$].want.level_out_db = lvl_out[LEVEL_W-1:0];
        plan[$].want.position_out = pos_out[POS_W-1:0];
    endfunction

    function automatic void plan_write(input logic [REG_IDX_W-1:0] idx, input int val);
        plan_row_t r;
        r = '{kind: ROW_WRITE, default: '0};
        r.reg_idx = idx;
        r.wdata   = val;
        plan.push_back(r);
    endfunction

    // ------------------------------------------------------------------
    // Drivers. All of them start and end at a falling edge.
    // ------------------------------------------------------------------

    // APB write with setup and access phases; the shadow follows at the accepting edge.
    task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            REG_POSITIONS: res_cfg  = val[RES_CFG_W-1:0];
            REG_HALF:      half_cfg = val[LEVEL_W-1:0];
            REG_TOP:       top_cfg  = val[LEVEL_W-1:0];
            REG_CUTOFF:    cut_cfg  = val[FRAC_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Offer one request; bursts of back-to-back requests with idle gaps
    // between them. Valid only drops when a real gap follows.
    task automatic send_request(input in_item_t req, input bit typed, input out_item_t want);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 70) : $urandom_range(1, 5);
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
        s_valid = 1'b1;
        s_data  = req;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(typed ? want : mapped_result(req));
        sent_count++;
        @(negedge aclk);
    endtask

    // Stop offering and wait until every owed result has come back.
    task automatic drain();
        s_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic int pick_level_reg();
        case ($urandom_range(0, 5))
            0:       return -32768;
            1:       return 32767;
            2:       return 0;
            3, 4:    return $urandom_range(0, 8000) - 4000;
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    // Fresh register set; small resolutions dominate so op 1 stays quick.
    task automatic random_settings();
        int pos_sel;
        int resv;
        int cutv;
        pos_sel = $urandom_range(0, 9);
        if (pos_sel <= 5)      resv = $urandom_range(2, 40);
        else if (pos_sel == 6) resv = $urandom_range(0, 2);
        else if (pos_sel == 7) resv = ($urandom_range(0, 1) == 0) ? 1024 : 2047;
        else if (pos_sel == 8) resv = $urandom_range(0, 2047);
        else                   resv = $urandom_range(100, 1024);
        case ($urandom_range(0, 5))
            0:       cutv = 0;
            1:       cutv = FRAC_ONE;
            2:       cutv = $urandom_range(FRAC_ONE + 1, 131071);
            3:       cutv = $urandom_range(0, 131071);
            default: cutv = $urandom_range(0, FRAC_ONE);
        endcase
        reg_write(REG_POSITIONS, resv);
        reg_write(REG_HALF, pick_level_reg());
        reg_write(REG_TOP, pick_level_reg());
        reg_write(REG_CUTOFF, cutv);
    endtask

    // Random request. Levels for op 1 often sit right on a law point or
    // one LSB off it, so exact matches and insertion points both get hit.
    function automatic in_item_t random_request();
        in_item_t    req;
        int unsigned n;
        int          lvl;
        n = last_index();
        req.op             = 1'($urandom_range(0, 1));
        req.fader_position = POS_W'(($urandom_range(0, 9) < 7) ? $urandom_range(0, n)
                                                                : $urandom_range(0, 1023));
        case ($urandom_range(0, 9))
            0, 1, 2, 3: lvl = fader_level($urandom_range(0, n), n);
            4, 5:       lvl = int'(fader_level($urandom_range(0, n), n))
                              + (($urandom_range(0, 1) == 0) ? -1 : 1);
            default:    lvl = $urandom_range(0, 65535);
        endcase
        req.level_in_db = lvl[LEVEL_W-1:0];
        return req;
    endfunction

    // ------------------------------------------------------------------
    // Receiver: stall pattern that switches between modes
    // ------------------------------------------------------------------
    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_HOLD} rx_mode_e;

    initial begin
        rx_mode_e rx_mode;
        int       rx_left;
        m_ready = 1'b0;
        rx_mode = RX_OPEN;
        rx_left = 0;
        forever begin
            @(negedge aclk);
            if (rx_left == 0) begin
                rx_mode = rx_mode_e'($urandom_range(0, 3));
                rx_left = (rx_mode == RX_HOLD) ? $urandom_range(5, 60)
                                               : $urandom_range(20, 300);
            end
            rx_left--;
            case (rx_mode)
                RX_OPEN:   m_ready = 1'b1;
                RX_COIN:   m_ready = 1'($urandom_range(0, 1));
                RX_SPARSE: m_ready = ($urandom_range(0, 7) == 0);
                default:   m_ready = 1'b0;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                fault_count++;
                if (fault_count <= 10)
                    $display("result with no request owed: level %0d position %0d",
                             m_data.level_out_db, m_data.position_out);
            end else begin
                want = pending_results.pop_front();
                if (m_data.level_out_db !== want.level_out_db ||
                    m_data.position_out !== want.position_out) begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("mismatch: level %0d want %0d, position %0d want %0d",
                                 m_data.level_out_db, want.level_out_db,
                                 m_data.position_out, want.position_out);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int batch;
        aresetn     = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        s_valid     = 1'b0;
        s_data      = '0;
        res_cfg     = RST_POSITIONS;
        half_cfg    = RST_HALF;
        top_cfg     = RST_TOP;
        cut_cfg     = RST_CUTOFF;
        fault_count = 0;
        sent_count  = 0;
        burst_left  = 0;

        // Reset settings: 1024 steps, +-10 dB around 0, cutoff step 204.
        // Step 0 sits at -10 dB linear minus the full 90 dB attenuation.
        plan_req_known(OP_POS_TO_DB, 1023, 0, 2560, 0);
        plan_req_known(OP_POS_TO_DB, 0, 0, -25600, 0);
        plan_req_known(OP_DB_TO_POS, 0, -32768, 0, 0);
        plan_req_known(OP_DB_TO_POS, 0, -25600, 0, 0);
        plan_req_known(OP_DB_TO_POS, 0, 32767, 0, 1023);
        plan_req_known(OP_DB_TO_POS, 0, 2560, 0, 1023);
        plan_req(OP_POS_TO_DB, 512, 0);
        plan_req(OP_POS_TO_DB, 204, 0);
        plan_req(OP_POS_TO_DB, 203, 0);
        plan_req(OP_DB_TO_POS, 0, 0);
        plan_req(OP_DB_TO_POS, 0, -12800);
        plan_req(OP_DB_TO_POS, 0, -25599);
        // Resolution below two clamps to two steps; cutoff step is then 0.
        plan_write(REG_POSITIONS, 0);
        plan_req_known(OP_POS_TO_DB, 1023, 0, 2560, 0);   // past the last step
        plan_req_known(OP_POS_TO_DB, 0, 0, -2560, 0);
        plan_req(OP_DB_TO_POS, 0, 0);
        plan_write(REG_POSITIONS, 1);
        plan_req(OP_POS_TO_DB, 1, 0);
        // Resolution above the maximum clamps, cutoff above one clamps.
        plan_write(REG_POSITIONS, 2047);
        plan_write(REG_CUTOFF, 131071);
        plan_req(OP_POS_TO_DB, 0, 0);
        plan_req(OP_POS_TO_DB, 500, 0);
        plan_req(OP_DB_TO_POS, 0, -1000);
        // Extreme dB settings, where the law saturates.
        plan_write(REG_POSITIONS, 16);
        plan_write(REG_HALF, -32768);
        plan_write(REG_TOP, 32767);
        plan_write(REG_CUTOFF, FRAC_ONE);
        plan_req(OP_POS_TO_DB, 0, 0);
        plan_req(OP_POS_TO_DB, 7, 0);
        plan_req(OP_DB_TO_POS, 0, 0);
        plan_write(REG_HALF, 32767);
        plan_write(REG_TOP, -32768);
        plan_write(REG_CUTOFF, 0);
        plan_req(OP_POS_TO_DB, 0, 0);
        plan_req(OP_POS_TO_DB, 15, 0);
        plan_req(OP_DB_TO_POS, 0, 1);

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_WRITE) begin
                drain();
                reg_write(plan[i].reg_idx, plan[i].wdata);
            end else begin
                send_request(plan[i].req, plan[i].typed, plan[i].want);
            end
        end

        // Random phases: new registers, then a batch of requests.
        while (sent_count < 1220) begin
            drain();
            random_settings();
            batch = $urandom_range(20, 80);
            repeat (batch) send_request(random_request(), 1'b0, '0);
        end

        drain();
        repeat (200) @(posedge aclk);
        if (fault_count == 0 && pending_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial begin
        #50_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
